// ----- src/cma_pkg.sv -----
// ----------------------------------------------------------------------------
// cma_pkg - shared constants and types of the confusion matrix accumulator
// Table geometry, operation codes and the write request of the count store.
// ----------------------------------------------------------------------------
package cma_pkg;

  // Table geometry
  localparam int NUM_CLASSES = 16;
  localparam int COUNT_BITS  = 32;
  localparam int NUM_CELLS   = NUM_CLASSES * NUM_CLASSES;
  localparam int CLS_BITS    = (NUM_CLASSES > 2) ? $clog2(NUM_CLASSES) : 1;
  localparam int ADDR_BITS   = $clog2(NUM_CELLS);

  // Result widths
  localparam int SUM_BITS   = 32;
  localparam int RATIO_BITS = 17;
  localparam int FRAC_BITS  = 16;

  // Class limit compared against 8-bit class fields
  localparam logic [8:0] CLS_LIMIT = 9'(NUM_CLASSES);
  localparam logic [COUNT_BITS-1:0] CELL_MAX = '1;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ROW   = 2'd1,
    OP_COL   = 2'd2,
    OP_TOTAL = 2'd3
  } op_e;

  // Write request to the count store
  typedef struct packed {
    logic                  en;
    logic [ADDR_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] data;
  } ram_wr_t;

endpackage

// ----- src/cma_count_ram.sv -----
// ----------------------------------------------------------------------------
// cma_count_ram - count store of the confusion matrix
// One write and one registered read a cycle; per-cell valid flags make an
// unwritten cell read as zero straight after reset.
// ----------------------------------------------------------------------------
module cma_count_ram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [cma_pkg::ADDR_BITS-1:0]  rd_addr_i,
  input  cma_pkg::ram_wr_t               wr_i,
  output logic [cma_pkg::COUNT_BITS-1:0] rd_data_o
);
  import cma_pkg::*;

  logic [COUNT_BITS-1:0] mem [NUM_CELLS];
  logic [NUM_CELLS-1:0]  valid_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rvld_q;

  // Storage array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem[rd_addr_i];
  end

  // Valid flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rvld_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rvld_q ? rdata_q : '0;

endmodule

// ----- src/cma_divider.sv -----
// ----------------------------------------------------------------------------
// cma_divider - serial fraction divider
// Restoring division giving (dividend << 16) / divisor, one quotient bit a
// cycle. Dividend never exceeds divisor, so the integer part is one bit.
// ----------------------------------------------------------------------------
module cma_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cma_pkg::SUM_BITS-1:0]   dividend_i,
  input  logic [cma_pkg::SUM_BITS-1:0]   divisor_i,
  output logic                           done_o,
  output logic [cma_pkg::RATIO_BITS-1:0] quot_o
);
  import cma_pkg::*;

  localparam int CNT_BITS = $clog2(RATIO_BITS);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(RATIO_BITS - 1);

  logic                  busy_q, done_q;
  logic [CNT_BITS-1:0]   cnt_q;
  logic [SUM_BITS:0]     rem_q, rem_d;
  logic [SUM_BITS-1:0]   div_q;
  logic [RATIO_BITS-1:0] quot_q, quot_d;
  logic                  ge;
  logic [SUM_BITS:0]     diff;
  logic [SUM_BITS:0]     kept;

  // One compare and subtract step
  always_comb begin
    diff   = rem_q - {1'b0, div_q};
    ge     = (rem_q >= {1'b0, div_q});
    kept   = ge ? diff : rem_q;
    rem_d  = {kept[SUM_BITS-1:0], 1'b0};
    quot_d = {quot_q[RATIO_BITS-2:0], ge};
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_BITS'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, dividend_i};
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- src/confusion_matrix_accumulator.sv -----
// ----------------------------------------------------------------------------
// confusion_matrix_accumulator - confusion matrix with error queries
// Counts samples per (true, predicted) class pair and reports row, column or
// whole-table error as counts and a 16-fraction-bit ratio.
// ----------------------------------------------------------------------------
// One request is taken at a time and yields one result; the input is not
// ready again until the result has been taken. An add goes through accept,
// cell read and saturating write. A row or column query walks the
// NUM_CLASSES cells of its row or column, a total query all NUM_CLASSES^2
// cells: one cell is read and summed per cycle from the count store, then
// the serial divider forms the ratio. Requests with an out-of-range class,
// and queries over an empty selection, answer after the accept or the walk
// with no division. The table reads as zero from reset on; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module confusion_matrix_accumulator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // true_class[7:0], predicted_class[15:8]
  input  logic [1:0]   s_axis_tuser,   // op[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [119:0] m_axis_tdata,   // wrong_count[31:0], total_count[63:32],
                                       // ratio[80:64], cell_count[112:81], zeros
  output logic [1:0]   m_axis_tuser    // empty_res[0], out_of_range[1]
);
  import cma_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ADD_RD   = 3'd1;
  localparam logic [2:0] ST_ADD_WR   = 3'd2;
  localparam logic [2:0] ST_WALK     = 3'd3;
  localparam logic [2:0] ST_DRAIN    = 3'd4;
  localparam logic [2:0] ST_DIV_GO   = 3'd5;
  localparam logic [2:0] ST_DIV_WAIT = 3'd6;

  localparam logic [CLS_BITS-1:0]  CLS_LAST = CLS_BITS'(NUM_CLASSES - 1);
  localparam logic [ADDR_BITS-1:0] ROW_STEP = ADDR_BITS'(NUM_CLASSES);

  logic [2:0]            state_q, state_d;
  op_e                   op_q, op_d;
  logic [CLS_BITS-1:0]   i_q, i_d, j_q, j_d;
  logic [ADDR_BITS-1:0]  addr_q, addr_d;
  logic                  acc_en_q, acc_en_d;
  logic                  diag_q, diag_d;
  logic                  acc_clr;
  logic [SUM_BITS-1:0]   wrong_q, wrong_d, total_q, total_d;

  logic                  out_vld_q, out_vld_d;
  logic [SUM_BITS-1:0]   o_wrong_q, o_wrong_d, o_total_q, o_total_d;
  logic [RATIO_BITS-1:0] o_ratio_q, o_ratio_d;
  logic                  o_empty_q, o_empty_d, o_oor_q, o_oor_d;
  logic [SUM_BITS-1:0]   o_cell_q, o_cell_d;

  op_e                   in_op;
  logic [7:0]            in_tc, in_pc;
  logic                  tc_ok, pc_ok, accept, walk_last;
  logic [CLS_BITS-1:0]   tc_idx, pc_idx;
  logic [COUNT_BITS-1:0] cell_rd, cell_inc;
  logic [SUM_BITS:0]     tot_sum, wrg_sum;
  ram_wr_t               ram_wr;
  logic                  div_start, div_done;
  logic [RATIO_BITS-1:0] div_quot;

  // Request fields
  assign in_op  = op_e'(s_axis_tuser);
  assign in_tc  = s_axis_tdata[7:0];
  assign in_pc  = s_axis_tdata[15:8];
  assign tc_ok  = ({1'b0, in_tc} < CLS_LIMIT);
  assign pc_ok  = ({1'b0, in_pc} < CLS_LIMIT);
  assign tc_idx = in_tc[CLS_BITS-1:0];
  assign pc_idx = in_pc[CLS_BITS-1:0];

  assign s_axis_tready = (state_q == ST_IDLE) && !out_vld_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Count store
  cma_count_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (addr_q),
    .wr_i      (ram_wr),
    .rd_data_o (cell_rd)
  );

  // Ratio divider
  cma_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (wrong_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Saturating increment of the cell read back
  assign cell_inc = (cell_rd == CELL_MAX) ? cell_rd : cell_rd + COUNT_BITS'(1);

  // Saturating accumulators
  always_comb begin
    tot_sum = {1'b0, total_q} + {1'b0, SUM_BITS'(cell_rd)};
    wrg_sum = {1'b0, wrong_q} + {1'b0, SUM_BITS'(cell_rd)};
    total_d = total_q;
    wrong_d = wrong_q;
    if (acc_clr) begin
      total_d = '0;
      wrong_d = '0;
    end else if (acc_en_q) begin
      total_d = tot_sum[SUM_BITS] ? '1 : tot_sum[SUM_BITS-1:0];
      if (!diag_q) begin
        wrong_d = wrg_sum[SUM_BITS] ? '1 : wrg_sum[SUM_BITS-1:0];
      end
    end
  end

  // Last cell of the walk
  always_comb begin
    case (op_q)
      OP_ROW:  walk_last = (j_q == CLS_LAST);
      OP_COL:  walk_last = (i_q == CLS_LAST);
      default: walk_last = (i_q == CLS_LAST) && (j_q == CLS_LAST);
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    i_d       = i_q;
    j_d       = j_q;
    addr_d    = addr_q;
    acc_en_d  = 1'b0;
    diag_d    = diag_q;
    acc_clr   = 1'b0;
    div_start = 1'b0;
    ram_wr    = '{en: 1'b0, addr: addr_q, data: cell_inc};

    out_vld_d = out_vld_q && !m_axis_tready;
    o_wrong_d = o_wrong_q;
    o_total_d = o_total_q;
    o_ratio_d = o_ratio_q;
    o_empty_d = o_empty_q;
    o_oor_d   = o_oor_q;
    o_cell_d  = o_cell_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = in_op;
          acc_clr = 1'b1;
          // Default result: all fields and flags zero
          o_wrong_d = '0;
          o_total_d = '0;
          o_ratio_d = '0;
          o_empty_d = 1'b0;
          o_oor_d   = 1'b0;
          o_cell_d  = '0;
          unique case (in_op)
            OP_ADD: begin
              if (tc_ok && pc_ok) begin
                addr_d  = ADDR_BITS'(tc_idx) * ROW_STEP + ADDR_BITS'(pc_idx);
                state_d = ST_ADD_RD;
              end else begin
                o_oor_d   = 1'b1;
                out_vld_d = 1'b1;
              end
            end
            OP_ROW: begin
              if (tc_ok) begin
                i_d     = tc_idx;
                j_d     = '0;
                addr_d  = ADDR_BITS'(tc_idx) * ROW_STEP;
                state_d = ST_WALK;
              end else begin
                o_oor_d   = 1'b1;
                out_vld_d = 1'b1;
              end
            end
            OP_COL: begin
              if (pc_ok) begin
                i_d     = '0;
                j_d     = pc_idx;
                addr_d  = ADDR_BITS'(pc_idx);
                state_d = ST_WALK;
              end else begin
                o_oor_d   = 1'b1;
                out_vld_d = 1'b1;
              end
            end
            OP_TOTAL: begin
              i_d     = '0;
              j_d     = '0;
              addr_d  = '0;
              state_d = ST_WALK;
            end
            default: ;
          endcase
        end
      end

      ST_ADD_RD: begin
        state_d = ST_ADD_WR;
      end

      ST_ADD_WR: begin
        ram_wr.en = 1'b1;
        o_cell_d  = SUM_BITS'(cell_inc);
        out_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end

      // Issue one cell read a cycle; the sum follows in the next cycle
      ST_WALK: begin
        acc_en_d = 1'b1;
        diag_d   = (i_q == j_q);
        case (op_q)
          OP_ROW: begin
            j_d    = j_q + CLS_BITS'(1);
            addr_d = addr_q + ADDR_BITS'(1);
          end
          OP_COL: begin
            i_d    = i_q + CLS_BITS'(1);
            addr_d = addr_q + ROW_STEP;
          end
          default: begin
            addr_d = addr_q + ADDR_BITS'(1);
            if (j_q == CLS_LAST) begin
              j_d = '0;
              i_d = i_q + CLS_BITS'(1);
            end else begin
              j_d = j_q + CLS_BITS'(1);
            end
          end
        endcase
        if (walk_last) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_d = ST_DIV_GO;
      end

      ST_DIV_GO: begin
        if (total_q == '0) begin
          o_empty_d = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          o_wrong_d = wrong_q;
          o_total_d = total_q;
          o_ratio_d = div_quot;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_en_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_en_q  <= acc_en_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    i_q       <= i_d;
    j_q       <= j_d;
    addr_q    <= addr_d;
    diag_q    <= diag_d;
    wrong_q   <= wrong_d;
    total_q   <= total_d;
    o_wrong_q <= o_wrong_d;
    o_total_q <= o_total_d;
    o_ratio_q <= o_ratio_d;
    o_empty_q <= o_empty_d;
    o_oor_q   <= o_oor_d;
    o_cell_q  <= o_cell_d;
  end

  // Result channel
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, o_cell_q, o_ratio_q, o_total_q, o_wrong_q};
  assign m_axis_tuser  = {o_oor_q, o_empty_q};

endmodule
